[rtl/bue_pkg.sv]
// Shared types, constants and helpers for the blending union evaluator.
package bue_pkg;

	localparam int VAL_W         = 32;
	localparam int LIMIT_W       = 17;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_AMPLITUDE    = 2'd0,
		REG_FIRST_SCALE  = 2'd1,
		REG_SECOND_SCALE = 2'd2,
		REG_LIMIT        = 2'd3
	} cfg_reg_t;

	// One request as it passes from the front end to the arithmetic pipeline.
	typedef struct packed {
		logic signed [VAL_W-1:0] first_value;
		logic signed [VAL_W-1:0] second_value;
		logic                    param_error;
	} item_t;

	// Magnitude of a signed word; the most negative value maps to 2^31.
	function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
		mag32 = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
	endfunction

endpackage

[rtl/bue_front.sv]
// Front end: takes requests, flags bad scale settings and queues them.
module bue_front import bue_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [VAL_W-1:0] first_value,
	input  logic signed [VAL_W-1:0] second_value,
	input  logic [VAL_W-1:0]        first_mag,
	input  logic [VAL_W-1:0]        second_mag,
	input  logic [LIMIT_W-1:0]      limit,
	output logic                    item_valid,
	output item_t                   item,
	input  logic                    item_take
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              wr_en;
	logic              rd_en;
	logic              bad_scale;
	item_t             new_item;

	// A zero scale always counts as an error, whatever the limit.
	assign bad_scale = (first_mag == '0) || (second_mag == '0)
		|| (first_mag < VAL_W'(limit)) || (second_mag < VAL_W'(limit));

	assign new_item.first_value  = first_value;
	assign new_item.second_value = second_value;
	assign new_item.param_error  = bad_scale;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign wr_en      = push && !full;
	assign item_valid = (count_q != '0);
	assign rd_en      = item_valid && item_take;
	assign item       = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + CNT_W'(wr_en) - CNT_W'(rd_en));
		end
	end

endmodule

[rtl/bue_back.sv]
// Back end: pipelined division, square root, blend and saturation.
module bue_back import bue_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  item_t                   item,
	output logic                    item_take,
	input  logic signed [VAL_W-1:0] amplitude,
	input  logic [VAL_W-1:0]        first_mag,
	input  logic [VAL_W-1:0]        second_mag,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [VAL_W-1:0] blended_value,
	output logic                    param_error,
	output logic                    saturated
);

	localparam int NW    = VAL_W + FRAC_BITS;  // width of |f| << F
	localparam int DDW   = VAL_W + FRAC_BITS;  // useful width of the denominator
	localparam int STEPS = VAL_W;
	localparam int SUM_W = VAL_W + 4;

	logic en;
	logic out_valid_q;
	logic [VAL_W-1:0] amp_mag;

	assign amp_mag   = mag32(amplitude);
	assign en        = !out_valid_q || pop;
	assign item_take = en;
	assign empty     = !out_valid_q;

	// Stage 1: request from the queue.
	logic                    v_s1, pe_s1;
	logic signed [VAL_W-1:0] f1_s1, f2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s1 <= item.first_value;
			f2_s1 <= item.second_value;
			pe_s1 <= item.param_error;
		end
	end

	// Stage 2: magnitudes and the check for a quotient of 2^31 or more.
	logic [VAL_W-1:0]        fm1_c, fm2_c;
	logic [NW-1:0]           n1_c, n2_c;
	logic                    v_s2, pe_s2, fl1_s2, fl2_s2;
	logic signed [VAL_W-1:0] f1_s2, f2_s2;
	logic [VAL_W-1:0]        fm1_s2, fm2_s2;

	assign fm1_c = mag32(f1_s1);
	assign fm2_c = mag32(f2_s1);
	assign n1_c  = {fm1_c, {FRAC_BITS{1'b0}}};
	assign n2_c  = {fm2_c, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s2  <= f1_s1;
			f2_s2  <= f2_s1;
			pe_s2  <= pe_s1;
			fm1_s2 <= fm1_c;
			fm2_s2 <= fm2_c;
			fl1_s2 <= {{(VAL_W-FRAC_BITS){1'b0}}, n1_c[NW-1:VAL_W-1]} >= {1'b0, first_mag};
			fl2_s2 <= {{(VAL_W-FRAC_BITS){1'b0}}, n2_c[NW-1:VAL_W-1]} >= {1'b0, second_mag};
		end
	end

	// Stage 3: squares of the two magnitudes for the root.
	logic                    v_s3, pe_s3, fl1_s3, fl2_s3;
	logic signed [VAL_W-1:0] f1_s3, f2_s3;
	logic [VAL_W-1:0]        fm1_s3, fm2_s3;
	logic [2*VAL_W-1:0]      sq1_s3, sq2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s3  <= f1_s2;
			f2_s3  <= f2_s2;
			pe_s3  <= pe_s2;
			fl1_s3 <= fl1_s2;
			fl2_s3 <= fl2_s2;
			fm1_s3 <= fm1_s2;
			fm2_s3 <= fm2_s2;
			sq1_s3 <= fm1_s2 * fm1_s2;
			sq2_s3 <= fm2_s2 * fm2_s2;
		end
	end

	// Shared pipeline: one quotient bit of each ratio and one root bit a stage.
	logic                    pv   [STEPS+1];
	logic                    ppe  [STEPS+1];
	logic signed [VAL_W-1:0] pf1  [STEPS+1];
	logic signed [VAL_W-1:0] pf2  [STEPS+1];
	logic [VAL_W-1:0]        pfm1 [STEPS+1];
	logic [VAL_W-1:0]        pfm2 [STEPS+1];
	logic                    pfl1 [STEPS+1];
	logic                    pfl2 [STEPS+1];
	logic [VAL_W-1:0]        pr1  [STEPS+1];
	logic [VAL_W-1:0]        pr2  [STEPS+1];
	logic [VAL_W-1:0]        pq1  [STEPS+1];
	logic [VAL_W-1:0]        pq2  [STEPS+1];
	logic [2*VAL_W-1:0]      px   [STEPS+1];
	logic [VAL_W+1:0]        psr  [STEPS+1];
	logic [VAL_W-1:0]        proot[STEPS+1];

	// Stage 4 opens the shared pipeline: partial remainders start at N >> 32.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv[0] <= 1'b0;
		end else if (en) begin
			pv[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ppe[0]   <= pe_s3;
			pf1[0]   <= f1_s3;
			pf2[0]   <= f2_s3;
			pfm1[0]  <= fm1_s3;
			pfm2[0]  <= fm2_s3;
			pfl1[0]  <= fl1_s3;
			pfl2[0]  <= fl2_s3;
			pr1[0]   <= {{(VAL_W-FRAC_BITS){1'b0}}, fm1_s3[VAL_W-1:VAL_W-FRAC_BITS]};
			pr2[0]   <= {{(VAL_W-FRAC_BITS){1'b0}}, fm2_s3[VAL_W-1:VAL_W-FRAC_BITS]};
			pq1[0]   <= '0;
			pq2[0]   <= '0;
			px[0]    <= sq1_s3 + sq2_s3;
			psr[0]   <= '0;
			proot[0] <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic          db1, db2;
		logic [VAL_W:0] n1, n2;
		logic          ge1, ge2, ge_r;
		logic [VAL_W+3:0] rn, rt;

		// Next dividend bit of |f| << F.
		if (STEPS - 1 - k >= FRAC_BITS) begin : g_bit
			assign db1 = pfm1[k][STEPS-1-k-FRAC_BITS];
			assign db2 = pfm2[k][STEPS-1-k-FRAC_BITS];
		end else begin : g_zero
			assign db1 = 1'b0;
			assign db2 = 1'b0;
		end

		assign n1   = {pr1[k], db1};
		assign n2   = {pr2[k], db2};
		assign ge1  = n1 >= {1'b0, first_mag};
		assign ge2  = n2 >= {1'b0, second_mag};
		assign rn   = {psr[k], px[k][2*VAL_W-1:2*VAL_W-2]};
		assign rt   = {2'b00, proot[k], 2'b01};
		assign ge_r = rn >= rt;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv[k+1] <= 1'b0;
			end else if (en) begin
				pv[k+1] <= pv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ppe[k+1]   <= ppe[k];
				pf1[k+1]   <= pf1[k];
				pf2[k+1]   <= pf2[k];
				pfm1[k+1]  <= pfm1[k];
				pfm2[k+1]  <= pfm2[k];
				pfl1[k+1]  <= pfl1[k];
				pfl2[k+1]  <= pfl2[k];
				pr1[k+1]   <= ge1 ? VAL_W'(n1 - {1'b0, first_mag}) : VAL_W'(n1);
				pr2[k+1]   <= ge2 ? VAL_W'(n2 - {1'b0, second_mag}) : VAL_W'(n2);
				pq1[k+1]   <= {pq1[k][VAL_W-2:0], ge1};
				pq2[k+1]   <= {pq2[k][VAL_W-2:0], ge2};
				px[k+1]    <= {px[k][2*VAL_W-3:0], 2'b00};
				psr[k+1]   <= ge_r ? (VAL_W+2)'(rn - rt) : (VAL_W+2)'(rn);
				proot[k+1] <= {proot[k][VAL_W-2:0], ge_r};
			end
		end
	end

	// Stage 5: squares of the ratios.
	logic                    v_s5, pe_s5, dz_s5;
	logic signed [VAL_W-1:0] f1_s5, f2_s5;
	logic [VAL_W-1:0]        root_s5;
	logic [2*VAL_W-3:0]      t1_s5, t2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= pv[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pe_s5   <= ppe[STEPS];
			f1_s5   <= pf1[STEPS];
			f2_s5   <= pf2[STEPS];
			root_s5 <= proot[STEPS];
			dz_s5   <= pfl1[STEPS] || pfl2[STEPS];
			t1_s5   <= pq1[STEPS][VAL_W-2:0] * pq1[STEPS][VAL_W-2:0];
			t2_s5   <= pq2[STEPS][VAL_W-2:0] * pq2[STEPS][VAL_W-2:0];
		end
	end

	// Stage 6 opens the blend division. A denominator past |a0| << F gives zero.
	logic [2*VAL_W-1:0] den_c;

	assign den_c = (2*VAL_W)'(64'(1) << FRAC_BITS)
		+ (2*VAL_W)'(t1_s5 >> FRAC_BITS) + (2*VAL_W)'(t2_s5 >> FRAC_BITS);

	logic                    ev   [STEPS+1];
	logic                    epe  [STEPS+1];
	logic signed [VAL_W-1:0] ef1  [STEPS+1];
	logic signed [VAL_W-1:0] ef2  [STEPS+1];
	logic [VAL_W-1:0]        eroot[STEPS+1];
	logic                    edz  [STEPS+1];
	logic [DDW-1:0]          eden [STEPS+1];
	logic [DDW-1:0]          erem [STEPS+1];
	logic [VAL_W-1:0]        equo [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev[0] <= 1'b0;
		end else if (en) begin
			ev[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			epe[0]   <= pe_s5;
			ef1[0]   <= f1_s5;
			ef2[0]   <= f2_s5;
			eroot[0] <= root_s5;
			edz[0]   <= dz_s5 || (|den_c[2*VAL_W-1:DDW]);
			eden[0]  <= den_c[DDW-1:0];
			erem[0]  <= {{(DDW-FRAC_BITS){1'b0}}, amp_mag[VAL_W-1:VAL_W-FRAC_BITS]};
			equo[0]  <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_blend
		logic         mb;
		logic [DDW:0] n;
		logic         ge;

		// Next dividend bit of |a0| << F.
		if (STEPS - 1 - k >= FRAC_BITS) begin : g_bit
			assign mb = amp_mag[STEPS-1-k-FRAC_BITS];
		end else begin : g_zero
			assign mb = 1'b0;
		end

		assign n  = {erem[k], mb};
		assign ge = n >= {1'b0, eden[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ev[k+1] <= 1'b0;
			end else if (en) begin
				ev[k+1] <= ev[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				epe[k+1]   <= epe[k];
				ef1[k+1]   <= ef1[k];
				ef2[k+1]   <= ef2[k];
				eroot[k+1] <= eroot[k];
				edz[k+1]   <= edz[k];
				eden[k+1]  <= eden[k];
				erem[k+1]  <= ge ? DDW'(n - {1'b0, eden[k]}) : DDW'(n);
				equo[k+1]  <= {equo[k][VAL_W-2:0], ge};
			end
		end
	end

	// Final stage: signed blend term, four-way sum and saturation.
	logic [VAL_W-1:0]        dq_c;
	logic signed [VAL_W:0]   d_c;
	logic signed [SUM_W-1:0] sum_c;
	logic                    hi_c, lo_c;
	localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'((64'sd1 <<< (VAL_W-1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] MIN_V = SUM_W'(-(64'sd1 <<< (VAL_W-1)));

	assign dq_c  = edz[STEPS] ? '0 : equo[STEPS];
	assign d_c   = amplitude[VAL_W-1] ? -$signed({1'b0, dq_c}) : $signed({1'b0, dq_c});
	assign sum_c = SUM_W'(ef1[STEPS]) + SUM_W'(ef2[STEPS])
		+ $signed({{(SUM_W-VAL_W){1'b0}}, eroot[STEPS]}) + SUM_W'(d_c);
	assign hi_c  = sum_c > MAX_V;
	assign lo_c  = sum_c < MIN_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ev[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			param_error <= epe[STEPS];
			if (epe[STEPS]) begin
				blended_value <= '0;
				saturated     <= 1'b0;
			end else begin
				blended_value <= hi_c ? VAL_W'(MAX_V) : (lo_c ? VAL_W'(MIN_V) : VAL_W'(sum_c));
				saturated     <= hi_c || lo_c;
			end
		end
	end

	// A parameter error never carries a value.
	a_perr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && param_error |-> blended_value == '0 && !saturated)
		else $error("parameter error result carries a value");

	// A clipped result sits at one end of the range.
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && saturated |->
		blended_value == VAL_W'(MAX_V) || blended_value == VAL_W'(MIN_V))
		else $error("saturated result not at a rail");

	// A result leaves the output register only when it was taken.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid_q) && !$past(pop) |-> out_valid_q)
		else $error("result dropped without a pop");

endmodule

[rtl/blending_union_eval_core.sv]
// Blending union evaluator: R-function union of two field values plus a blend term.
//
// Requests enter through push/full with first_value and second_value in signed
// fixed point (FRAC_BITS fraction bits). A request is taken when push is high
// and full is low. Results leave through empty/pop: the oldest result sits on
// blended_value, param_error and saturated while empty is low and is taken
// when pop is high. Configuration is written through cfg_valid/cfg_ready with
// cfg_index selecting amplitude, first scale, second scale or limit; writes
// are accepted every cycle and must only be made while the block is idle.
//
// One request is taken per cycle while full is low. The two ratio divisions and
// the square root share a 32-stage bit-serial pipeline, and the blend division
// takes another 32. A four-entry queue sits in front of the pipeline. When pop
// is held low the whole pipeline freezes behind the output register and the
// queue fills, after which full rises. Reset empties the queue and pipeline and
// loads the registers with amplitude 1.0, both scales 1.0 and a limit of one LSB.
module blending_union_eval_core import bue_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [VAL_W-1:0] first_value,
	input  logic signed [VAL_W-1:0] second_value,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [VAL_W-1:0] blended_value,
	output logic                    param_error,
	output logic                    saturated,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [VAL_W-1:0]        cfg_data
);

	logic signed [VAL_W-1:0] amplitude_q;
	logic signed [VAL_W-1:0] first_scale_q;
	logic signed [VAL_W-1:0] second_scale_q;
	logic [LIMIT_W-1:0]      limit_q;
	logic [VAL_W-1:0]        first_mag;
	logic [VAL_W-1:0]        second_mag;
	logic                    item_valid;
	logic                    item_take;
	item_t                   item;

	assign cfg_ready  = 1'b1;
	assign first_mag  = mag32(first_scale_q);
	assign second_mag = mag32(second_scale_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q    <= VAL_W'(32'sd1 <<< FRAC_BITS_DEF);
			first_scale_q  <= VAL_W'(32'sd1 <<< FRAC_BITS_DEF);
			second_scale_q <= VAL_W'(32'sd1 <<< FRAC_BITS_DEF);
			limit_q        <= LIMIT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_AMPLITUDE:    amplitude_q    <= cfg_data;
				REG_FIRST_SCALE:  first_scale_q  <= cfg_data;
				REG_SECOND_SCALE: second_scale_q <= cfg_data;
				REG_LIMIT:        limit_q        <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	// Request intake and scale check.
	bue_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.first_value  (first_value),
		.second_value (second_value),
		.first_mag    (first_mag),
		.second_mag   (second_mag),
		.limit        (limit_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	// Arithmetic pipeline and output register.
	bue_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (item),
		.item_take     (item_take),
		.amplitude     (amplitude_q),
		.first_mag     (first_mag),
		.second_mag    (second_mag),
		.empty         (empty),
		.pop           (pop),
		.blended_value (blended_value),
		.param_error   (param_error),
		.saturated     (saturated)
	);

endmodule

[tb/blending_union_eval_core_checker.sv]
// Result checker for the blending union evaluator: predicts each result and compares it.
`timescale 1ns / 100ps
module blending_union_eval_core_checker import bue_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic signed [VAL_W-1:0] first_value,
	input  logic signed [VAL_W-1:0] second_value,
	input  logic                    empty,
	input  logic                    pop,
	input  logic signed [VAL_W-1:0] blended_value,
	input  logic                    param_error,
	input  logic                    saturated,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [VAL_W-1:0]        cfg_data,
	output int                      fail_count,
	output int                      pending,
	output int                      results_seen,
	output int                      saturations_seen,
	output int                      errors_seen
);

	localparam int FB = FRAC_BITS_DEF;

	typedef struct {
		logic [31:0] value;
		logic        perr;
		logic        sat;
	} blend_result_t;

	// Local copy of the configuration registers.
	logic signed [31:0] amp_q, scale1_q, scale2_q;
	logic [16:0]        limit_q;

	blend_result_t expected_results[$];

	assign pending = expected_results.size();

	// Integer square root, bit by bit from the top.
	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] res, bit_w;
		res   = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > x)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (x >= res + bit_w) begin
				x   = x - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// Square of the scaled ratio, capped where it would overflow.
	function automatic logic [63:0] scaled_square(input logic [63:0] fmag,
	                                             input logic [63:0] amag);
		logic [63:0] q;
		q = (fmag << FB) / amag;
		if (q >= (64'd1 << 31))
			return 64'd1 << 62;
		return (q * q) >> FB;
	endfunction

	function automatic blend_result_t blend_union(input logic signed [31:0] f1,
	                                              input logic signed [31:0] f2);
		blend_result_t    r;
		logic [63:0]      m1, m2, mf1, mf2, den, dmag;
		logic signed [63:0] d, sum;
		m1  = {32'd0, mag32(scale1_q)};
		m2  = {32'd0, mag32(scale2_q)};
		mf1 = {32'd0, mag32(f1)};
		mf2 = {32'd0, mag32(f2)};
		r.value = 0;
		r.perr  = 0;
		r.sat   = 0;
		if (m1 == 0 || m2 == 0 || m1 < limit_q || m2 < limit_q) begin
			r.perr = 1;
			return r;
		end
		den = (64'd1 << FB) + scaled_square(mf1, m1) + scaled_square(mf2, m2);
		if (den > (64'd1 << 62))
			den = 64'd1 << 62;
		dmag = ({32'd0, mag32(amp_q)} << FB) / den;
		d    = amp_q < 0 ? -$signed(dmag) : $signed(dmag);
		sum  = 64'(f1) + 64'(f2) + $signed(root_floor(mf1 * mf1 + mf2 * mf2)) + d;
		if (sum > 64'sh7FFFFFFF) begin
			sum   = 64'sh7FFFFFFF;
			r.sat = 1;
		end else if (sum < -64'sh80000000) begin
			sum   = -64'sh80000000;
			r.sat = 1;
		end
		r.value = sum[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("%0t: %s got %h wanted %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Follow configuration writes and accepted requests; check accepted results.
	always @(posedge clk or negedge arst_n) begin
		blend_result_t want;
		if (!arst_n) begin
			amp_q    <= 32'sd65536;
			scale1_q <= 32'sd65536;
			scale2_q <= 32'sd65536;
			limit_q  <= 17'd1;
			expected_results.delete();
			fail_count       <= 0;
			results_seen     <= 0;
			saturations_seen <= 0;
			errors_seen      <= 0;
		end else begin
			if (push && !full)
				expected_results.push_back(blend_union(first_value, second_value));
			if (pop && !empty) begin
				results_seen <= results_seen + 1;
				if (saturated) saturations_seen <= saturations_seen + 1;
				if (param_error) errors_seen <= errors_seen + 1;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", blended_value, 0);
				end else begin
					want = expected_results.pop_front();
					if (blended_value !== want.value)
						report_mismatch("blended_value", blended_value, want.value);
					if (param_error !== want.perr)
						report_mismatch("param_error", param_error, want.perr);
					if (saturated !== want.sat)
						report_mismatch("saturated", saturated, want.sat);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_AMPLITUDE:    amp_q    <= cfg_data;
					REG_FIRST_SCALE:  scale1_q <= cfg_data;
					REG_SECOND_SCALE: scale2_q <= cfg_data;
					REG_LIMIT:        limit_q  <= cfg_data[16:0];
				endcase
			end
		end
	end

endmodule

[tb/blending_union_eval_core_tb.sv]
// Top of the blending union evaluator testbench: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module blending_union_eval_core_tb;
	import bue_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	logic                    clk, arst_n;
	logic                    push, full, empty, pop;
	logic signed [VAL_W-1:0] first_value, second_value, blended_value;
	logic                    param_error, saturated;
	logic                    cfg_valid, cfg_ready;
	logic [1:0]              cfg_index;
	logic [VAL_W-1:0]        cfg_data;
	int                      fail_count, pending, results_seen, saturations_seen, errors_seen;
	int                      idle_cycles;
	bit                      calm;
	int                      phase_count;

	blending_union_eval_core u_top (.*);

	blending_union_eval_core_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Result side takes results at random, with a calm stretch.
	initial pop = 0;
	always @(posedge clk)
		pop <= calm ? 1'b1 : ($urandom_range(99) >= 21);

	// Watchdog: ends the run after too long with nothing accepted.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Watchdog expired");
			$display("Mismatches found");
			$finish;
		end
	end

	// Random field value, biased towards extremes and small magnitudes.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF - $urandom_range(3);
			1: return 32'h80000000 + $urandom_range(3);
			2: return $urandom_range(8) * 32'h10000 - 32'h40000 + $urandom_range(255);
			3: return $signed($urandom_range(65535)) - 32'sd32768;
			default: return $urandom();
		endcase
	endfunction

	// Write one register and wait for the handshake.
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// Send one request, with a random idle gap unless calm.
	task automatic send_request(input logic [31:0] a, input logic [31:0] b);
		while (!calm && $urandom_range(99) < 21) begin
			push <= 0;
			@(posedge clk);
		end
		push         <= 1;
		first_value  <= a;
		second_value <= b;
		do @(posedge clk); while (full);
	endtask

	// Stop pushing, let every result come back, then wait with push held low.
	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic random_burst(input int n);
		repeat (n) send_request(pick_value(), pick_value());
		drain();
	endtask

	initial begin
		push = 0; first_value = 0; second_value = 0;
		cfg_valid = 0; cfg_index = REG_AMPLITUDE; cfg_data = 0;
		calm = 0; idle_cycles = 0; phase_count = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed requests at reset configuration: extremes and zeros.
		send_request(0, 0);
		send_request(32'h7FFFFFFF, 32'h7FFFFFFF);
		send_request(32'h80000000, 32'h80000000);
		send_request(32'h80000000, 32'h7FFFFFFF);
		send_request(32'h00010000, 32'hFFFF0000);
		send_request(32'hFFFFFFFF, 32'h00000001);
		send_request(32'h7FFFFFFF, 32'h80000000);
		send_request(32'h00008000, 32'h00008000);
		drain();

		// A scale of zero counts as an error even when the limit is zero.
		write_reg(REG_LIMIT, 0);
		write_reg(REG_FIRST_SCALE, 0);
		send_request(32'h00010000, 32'h00020000);
		drain();
		// Scales just at and just below the limit, with the largest limit.
		write_reg(REG_LIMIT, 32'h1FFFF);
		write_reg(REG_FIRST_SCALE, 32'hFFFE0001);
		write_reg(REG_SECOND_SCALE, 32'h1FFFF);
		send_request(32'h00030000, 32'hFFFD0000);
		drain();
		write_reg(REG_SECOND_SCALE, 32'h1FFFE);
		send_request(32'h00030000, 32'hFFFD0000);
		drain();
		// Extreme amplitude and the smallest and largest scale magnitudes.
		write_reg(REG_LIMIT, 1);
		write_reg(REG_AMPLITUDE, 32'h7FFFFFFF);
		write_reg(REG_FIRST_SCALE, 1);
		write_reg(REG_SECOND_SCALE, 32'h80000000);
		send_request(0, 0);
		send_request(32'h7FFFFFFF, 1);
		send_request(32'h80000000, 32'h80000000);
		drain();
		write_reg(REG_AMPLITUDE, 32'h80000000);
		write_reg(REG_FIRST_SCALE, 32'hFFFFFFFF);
		send_request(0, 0);
		send_request(32'h00000001, 32'h80000000);
		drain();

		// Random phases, each under a fresh configuration.
		for (int ph = 0; ph < 8; ph++) begin
			phase_count++;
			calm = (ph == 3);
			write_reg(REG_AMPLITUDE, pick_value());
			write_reg(REG_FIRST_SCALE, ph == 5 ? $urandom_range(3) : pick_value());
			write_reg(REG_SECOND_SCALE, pick_value());
			write_reg(REG_LIMIT, ph == 6 ? 32'h1FFFF : $urandom_range(ph[0] ? 65536 : 16));
			random_burst(55);
		end
		calm = 0;

		$display("Ran %0d results over %0d random settings: %0d saturated, %0d scale errors",
		         results_seen, phase_count, saturations_seen, errors_seen);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[blending_union_eval_core.f]
rtl/bue_pkg.sv
rtl/bue_front.sv
rtl/bue_back.sv
rtl/blending_union_eval_core.sv
tb/blending_union_eval_core_checker.sv
tb/blending_union_eval_core_tb.sv
